// ===== rtl/core/gclk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gclk_pkg;

  localparam int unsigned MAX_BASE_MINUTES_DEF      = 180;
  localparam int unsigned MAX_INCREMENT_SECONDS_DEF = 60;

  localparam int unsigned BASE_MINUTES_W = 8;
  localparam int unsigned INCREMENT_W    = 6;
  localparam int unsigned CFG_DATA_W     = 8;
  localparam int unsigned CFG_INDEX_W    = 1;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned COUNT_W        = 16;

  // 180 min * 60000 needs 24 bits; the product stays well inside this width
  localparam int unsigned START_MS_W = BASE_MINUTES_W + 17;
  localparam int unsigned INC_MS_W   = INCREMENT_W + 10;

  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned MS_PER_SECOND      = 1000;
  localparam int unsigned MS_PER_MINUTE      = SECONDS_PER_MINUTE * MS_PER_SECOND;

  localparam logic SIDE_WHITE = 1'b0;
  localparam logic SIDE_BLACK = 1'b1;

  typedef enum logic [1:0] {
    OP_NEW_GAME = 2'd0,
    OP_PRESS    = 2'd1,
    OP_PAUSE    = 2'd2,
    OP_TICK     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_MINUTES      = 1'd0,
    REG_INCREMENT_SECONDS = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    mode_t               run_state;
    logic                side_to_move;
    logic                flagged_side;
    logic [TIME_W-1:0]   white_ms;
    logic [TIME_W-1:0]   black_ms;
    logic [COUNT_W-1:0]  white_moves;
    logic [COUNT_W-1:0]  black_moves;
    logic                flag_fell;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/gclk_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gclk_in_if;
  import gclk_pkg::*;

  logic              valid;
  logic              ready;
  opcode_t           opcode;
  logic              side;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, opcode, side, now_ms, input ready);
  modport sink   (input valid, opcode, side, now_ms, output ready);
endinterface

interface gclk_out_if;
  import gclk_pkg::*;

  logic               valid;
  logic               ready;
  mode_t              run_state;
  logic               side_to_move;
  logic               flagged_side;
  logic [TIME_W-1:0]  white_ms;
  logic [TIME_W-1:0]  black_ms;
  logic [COUNT_W-1:0] white_moves;
  logic [COUNT_W-1:0] black_moves;
  logic               flag_fell;

  modport source (
    output valid, run_state, side_to_move, flagged_side, white_ms, black_ms,
           white_moves, black_moves, flag_fell,
    input  ready
  );
  modport sink (
    input  valid, run_state, side_to_move, flagged_side, white_ms, black_ms,
           white_moves, black_moves, flag_fell,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/two_player_game_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-player game clock with Fischer increment. Every event on in_ch (new game,
// press, pause toggle, millisecond tick) produces exactly one status item on
// out_ch. Clock state registers update at the transfer edge; the status goes
// into the output register, or the skid register while out_ch stalls, so a
// new event can be taken every cycle while the skid register is empty. The
// two-deep output stage (output plus skid register) lets one more event in
// while one is stalled; in_ch.ready drops only while two status items wait.
// Config writes take effect at the write edge and saturate at the limits
// (increment on low cfg_data bits); base_minutes 0 is unlimited (count-up).

module two_player_game_clock #(
  parameter int unsigned MAX_BASE_MINUTES      = gclk_pkg::MAX_BASE_MINUTES_DEF,
  parameter int unsigned MAX_INCREMENT_SECONDS = gclk_pkg::MAX_INCREMENT_SECONDS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [gclk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [gclk_pkg::CFG_DATA_W-1:0]  cfg_data,
  gclk_in_if.sink                              in_ch,
  gclk_out_if.source                           out_ch
);
  import gclk_pkg::*;

  // configuration
  logic [BASE_MINUTES_W-1:0] base_minutes;
  logic [INCREMENT_W-1:0]    increment_seconds;

  // clock state
  mode_t              mode;
  logic               mover;
  logic               loser;
  logic [TIME_W-1:0]  white_time;
  logic [TIME_W-1:0]  black_time;
  logic [COUNT_W-1:0] white_count;
  logic [COUNT_W-1:0] black_count;
  logic [TIME_W-1:0]  last_sample;

  mode_t              mode_next;
  logic               mover_next;
  logic               loser_next;
  logic [TIME_W-1:0]  white_time_next;
  logic [TIME_W-1:0]  black_time_next;
  logic [COUNT_W-1:0] white_count_next;
  logic [COUNT_W-1:0] black_count_next;
  logic [TIME_W-1:0]  last_sample_next;
  logic               fell;

  // output stage
  result_t out_data;
  logic    out_valid;
  result_t skid_data;
  logic    skid_valid;
  result_t result;

  logic in_fire;
  logic out_fire;

  logic                    unlimited;
  logic [START_MS_W-1:0]   start_ms;
  logic [INC_MS_W-1:0]     inc_ms;
  logic [TIME_W-1:0]       inc_add;
  logic [TIME_W-1:0]       elapsed;
  logic [TIME_W-1:0]       mover_time;
  logic [TIME_W-1:0]       tick_time;
  logic                    expired;

  logic [BASE_MINUTES_W-1:0] base_sat;
  logic [INCREMENT_W-1:0]    inc_sat;

  assign in_ch.ready = !skid_valid;
  assign in_fire     = in_ch.valid && !skid_valid;
  assign out_fire    = out_valid && out_ch.ready;

  // saturating configuration values
  always_comb begin
    if (32'(cfg_data) > 32'(MAX_BASE_MINUTES)) begin
      base_sat = BASE_MINUTES_W'(MAX_BASE_MINUTES);
    end else begin
      base_sat = cfg_data[BASE_MINUTES_W-1:0];
    end
    if (32'(cfg_data[INCREMENT_W-1:0]) > 32'(MAX_INCREMENT_SECONDS)) begin
      inc_sat = INCREMENT_W'(MAX_INCREMENT_SECONDS);
    end else begin
      inc_sat = cfg_data[INCREMENT_W-1:0];
    end
  end

  assign unlimited  = (base_minutes == '0);
  assign start_ms   = START_MS_W'(base_minutes) * START_MS_W'(MS_PER_MINUTE);
  assign inc_ms     = INC_MS_W'(increment_seconds) * INC_MS_W'(MS_PER_SECOND);
  assign inc_add    = unlimited ? '0 : TIME_W'(inc_ms);
  assign elapsed    = in_ch.now_ms - last_sample;
  assign mover_time = (mover == SIDE_BLACK) ? black_time : white_time;
  assign expired    = !unlimited && (elapsed >= mover_time);

  always_comb begin
    if (unlimited) begin
      tick_time = mover_time + elapsed;
    end else if (expired) begin
      tick_time = '0;
    end else begin
      tick_time = mover_time - elapsed;
    end
  end

  always_comb begin
    mode_next        = mode;
    mover_next       = mover;
    loser_next       = loser;
    white_time_next  = white_time;
    black_time_next  = black_time;
    white_count_next = white_count;
    black_count_next = black_count;
    last_sample_next = last_sample;
    fell             = 1'b0;

    unique case (in_ch.opcode)
      OP_NEW_GAME: begin
        white_time_next  = unlimited ? '0 : TIME_W'(start_ms);
        black_time_next  = unlimited ? '0 : TIME_W'(start_ms);
        white_count_next = '0;
        black_count_next = '0;
        mode_next        = MODE_IDLE;
        mover_next       = SIDE_WHITE;
        loser_next       = SIDE_WHITE;
        last_sample_next = in_ch.now_ms;
      end
      OP_PRESS: begin
        priority if (mode == MODE_IDLE) begin
          // either button starts the game, white always moves first
          mover_next       = SIDE_WHITE;
          mode_next        = MODE_RUNNING;
          last_sample_next = in_ch.now_ms;
        end else if (mode == MODE_RUNNING && in_ch.side == mover) begin
          if (in_ch.side == SIDE_BLACK) begin
            black_count_next = black_count + 1'b1;
            black_time_next  = black_time + inc_add;
          end else begin
            white_count_next = white_count + 1'b1;
            white_time_next  = white_time + inc_add;
          end
          mover_next = !in_ch.side;
        end else begin
          // wrong side, paused or finished: no change
        end
      end
      OP_PAUSE: begin
        priority if (mode == MODE_RUNNING) begin
          mode_next = MODE_PAUSED;
        end else if (mode == MODE_PAUSED || mode == MODE_IDLE) begin
          mode_next        = MODE_RUNNING;
          last_sample_next = in_ch.now_ms;
        end else begin
          // finished: no change
        end
      end
      OP_TICK: begin
        last_sample_next = in_ch.now_ms;
        if (mode == MODE_RUNNING) begin
          if (mover == SIDE_BLACK) begin
            black_time_next = tick_time;
          end else begin
            white_time_next = tick_time;
          end
          if (expired) begin
            loser_next = mover;
            mode_next  = MODE_FINISHED;
            fell       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.run_state    = mode_next;
    result.side_to_move = mover_next;
    result.flagged_side = loser_next;
    result.white_ms     = white_time_next;
    result.black_ms     = black_time_next;
    result.white_moves  = white_count_next;
    result.black_moves  = black_count_next;
    result.flag_fell    = fell;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_minutes      <= '0;
      increment_seconds <= '0;
      mode              <= MODE_IDLE;
      mover             <= SIDE_WHITE;
      loser             <= SIDE_WHITE;
      white_time        <= '0;
      black_time        <= '0;
      white_count       <= '0;
      black_count       <= '0;
      last_sample       <= '0;
      out_valid         <= 1'b0;
      skid_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BASE_MINUTES:      base_minutes      <= base_sat;
          REG_INCREMENT_SECONDS: increment_seconds <= inc_sat;
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        mode        <= mode_next;
        mover       <= mover_next;
        loser       <= loser_next;
        white_time  <= white_time_next;
        black_time  <= black_time_next;
        white_count <= white_count_next;
        black_count <= black_count_next;
        last_sample <= last_sample_next;
      end

      // skid is empty whenever an event is taken
      priority if (in_fire && (!out_valid || out_fire)) begin
        out_valid <= 1'b1;
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end else if (out_fire && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (!out_valid || out_fire)) begin
      out_data <= result;
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
    if (in_fire && out_valid && !out_fire) begin
      skid_data <= result;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.run_state    = out_data.run_state;
  assign out_ch.side_to_move = out_data.side_to_move;
  assign out_ch.flagged_side = out_data.flagged_side;
  assign out_ch.white_ms     = out_data.white_ms;
  assign out_ch.black_ms     = out_data.black_ms;
  assign out_ch.white_moves  = out_data.white_moves;
  assign out_ch.black_moves  = out_data.black_moves;
  assign out_ch.flag_fell    = out_data.flag_fell;

  // a status item never sits in the skid register behind an empty output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a status item while output is empty");

  // an event taken against a stalled output must land in the skid register
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (in_fire && out_valid && !out_ch.ready) |=> skid_valid)
    else $error("event taken during output stall was not held");

  // a fallen flag always comes with a finished game
  a_flag_finished: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.flag_fell) |-> (out_data.run_state == MODE_FINISHED))
    else $error("flag fell without the game finishing");

  // configuration stays within its limits
  a_cfg_limits: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (32'(base_minutes) <= 32'(MAX_BASE_MINUTES)
                   && 32'(increment_seconds) <= 32'(MAX_INCREMENT_SECONDS)))
    else $error("configuration register above its limit");

endmodule

`default_nettype wire
